[sv/cts_pkg.sv]
// Shared types, command codes and calendar constants for the calendar time stepper.
`timescale 1ns / 1ps

package cts_pkg;

	// Calendar geometry
	localparam int DAYS_PER_YEAR  = 364;
	localparam int DAYS_PER_MONTH = 28;
	localparam int DAYS_PER_WEEK  = 7;

	// Field widths
	localparam int CMD_W    = 4;
	localparam int YEAR_W   = 16;
	localparam int DAY_W    = 9;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;

	// Day sum needs one bit more than a day
	localparam int DAY_SUM_W = DAY_W + 1;

	// Season start days
	localparam logic [DAY_W-1:0] SEASON1_DAY = DAY_W'(1);
	localparam logic [DAY_W-1:0] SEASON2_DAY = DAY_W'(92);
	localparam logic [DAY_W-1:0] SEASON3_DAY = DAY_W'(183);
	localparam logic [DAY_W-1:0] SEASON4_DAY = DAY_W'(274);

	// Time-of-day limits
	localparam logic [HOUR_W-1:0]   HOUR_MAX   = HOUR_W'(23);
	localparam logic [MINUTE_W-1:0] MINUTE_MAX = MINUTE_W'(59);
	localparam logic [SECOND_W-1:0] SECOND_MAX = SECOND_W'(59);

	// Stream payload widths
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE   = 4'd0,
		CMD_SECOND = 4'd1,
		CMD_MINUTE = 4'd2,
		CMD_HOUR   = 4'd3,
		CMD_DAY    = 4'd4,
		CMD_WEEK   = 4'd5,
		CMD_MONTH  = 4'd6,
		CMD_SEASON = 4'd7,
		CMD_YEAR   = 4'd8,
		CMD_LOAD   = 4'd9
	} cmd_t;

	// Calendar state
	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [DAY_W-1:0]    day;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
	} cal_t;

	// Registered input item
	typedef struct packed {
		logic [CMD_W-1:0] command;
		cal_t             load;
	} item_t;

	// Change flags of one step
	typedef struct packed {
		logic time_touched;
		logic date_touched;
	} flags_t;

endpackage

[sv/cts_step.sv]
// Next-state logic of the calendar: carries, day wrap, season jump and load clamping.
`timescale 1ns / 1ps

module cts_step (
	input  cts_pkg::cal_t   cal,
	input  cts_pkg::item_t  item,
	output cts_pkg::cal_t   cal_next,
	output cts_pkg::flags_t flags
);

	cts_pkg::cmd_t                        cmd;
	logic                                 sec_wrap;
	logic                                 min_inc;
	logic                                 min_wrap;
	logic                                 hour_inc;
	logic                                 hour_wrap;
	logic [cts_pkg::DAY_SUM_W-1:0]        day_add;
	logic [cts_pkg::DAY_SUM_W-1:0]        day_sum;
	logic                                 day_wrap;
	logic [cts_pkg::DAY_W-1:0]            day_stepped;
	logic [cts_pkg::DAY_W-1:0]            load_day;
	logic [cts_pkg::HOUR_W-1:0]           load_hour;
	logic [cts_pkg::MINUTE_W-1:0]         load_minute;
	logic [cts_pkg::SECOND_W-1:0]         load_second;

	assign cmd = cts_pkg::cmd_t'(item.command);

	// Carry chain second -> minute -> hour -> day
	assign sec_wrap  = (cmd == cts_pkg::CMD_SECOND) && (cal.second >= cts_pkg::SECOND_MAX);
	assign min_inc   = (cmd == cts_pkg::CMD_MINUTE) || sec_wrap;
	assign min_wrap  = min_inc && (cal.minute >= cts_pkg::MINUTE_MAX);
	assign hour_inc  = (cmd == cts_pkg::CMD_HOUR) || min_wrap;
	assign hour_wrap = hour_inc && (cal.hour >= cts_pkg::HOUR_MAX);

	// Days to add for day, week and month steps and for a carry out of the hour
	always_comb begin
		if (hour_wrap || cmd == cts_pkg::CMD_DAY) begin
			day_add = cts_pkg::DAY_SUM_W'(1);
		end else if (cmd == cts_pkg::CMD_WEEK) begin
			day_add = cts_pkg::DAY_SUM_W'(cts_pkg::DAYS_PER_WEEK);
		end else if (cmd == cts_pkg::CMD_MONTH) begin
			day_add = cts_pkg::DAY_SUM_W'(cts_pkg::DAYS_PER_MONTH);
		end else begin
			day_add = '0;
		end
	end

	assign day_sum     = {1'b0, cal.day} + day_add;
	assign day_wrap    = day_sum > cts_pkg::DAY_SUM_W'(cts_pkg::DAYS_PER_YEAR);
	assign day_stepped = day_wrap
		? cts_pkg::DAY_W'(day_sum - cts_pkg::DAY_SUM_W'(cts_pkg::DAYS_PER_YEAR))
		: day_sum[cts_pkg::DAY_W-1:0];

	// Load clamping
	always_comb begin
		if (item.load.day == '0) begin
			load_day = cts_pkg::SEASON1_DAY;
		end else if (item.load.day > cts_pkg::DAY_W'(cts_pkg::DAYS_PER_YEAR)) begin
			load_day = cts_pkg::DAY_W'(cts_pkg::DAYS_PER_YEAR);
		end else begin
			load_day = item.load.day;
		end
		load_hour   = (item.load.hour > cts_pkg::HOUR_MAX) ? cts_pkg::HOUR_MAX : item.load.hour;
		load_minute = (item.load.minute > cts_pkg::MINUTE_MAX)
			? cts_pkg::MINUTE_MAX : item.load.minute;
		load_second = (item.load.second > cts_pkg::SECOND_MAX)
			? cts_pkg::SECOND_MAX : item.load.second;
	end

	// Next calendar value
	always_comb begin
		cal_next = cal;
		case (cmd)
			cts_pkg::CMD_SECOND, cts_pkg::CMD_MINUTE, cts_pkg::CMD_HOUR,
			cts_pkg::CMD_DAY, cts_pkg::CMD_WEEK, cts_pkg::CMD_MONTH: begin
				if (cmd == cts_pkg::CMD_SECOND) begin
					cal_next.second = sec_wrap ? '0 : cal.second + 1'b1;
				end
				if (min_inc) begin
					cal_next.minute = min_wrap ? '0 : cal.minute + 1'b1;
				end
				if (hour_inc) begin
					cal_next.hour = hour_wrap ? '0 : cal.hour + 1'b1;
				end
				if (day_add != '0) begin
					cal_next.day = day_stepped;
					if (day_wrap) begin
						cal_next.year = cal.year + 1'b1;
					end
				end
			end
			cts_pkg::CMD_SEASON: begin
				cal_next.hour   = '0;
				cal_next.minute = '0;
				cal_next.second = '0;
				if (cal.day < cts_pkg::SEASON2_DAY) begin
					cal_next.day = cts_pkg::SEASON2_DAY;
				end else if (cal.day < cts_pkg::SEASON3_DAY) begin
					cal_next.day = cts_pkg::SEASON3_DAY;
				end else if (cal.day < cts_pkg::SEASON4_DAY) begin
					cal_next.day = cts_pkg::SEASON4_DAY;
				end else begin
					cal_next.day  = cts_pkg::SEASON1_DAY;
					cal_next.year = cal.year + 1'b1;
				end
			end
			cts_pkg::CMD_YEAR: begin
				cal_next.year = cal.year + 1'b1;
			end
			cts_pkg::CMD_LOAD: begin
				cal_next.year   = item.load.year;
				cal_next.day    = load_day;
				cal_next.hour   = load_hour;
				cal_next.minute = load_minute;
				cal_next.second = load_second;
			end
			default: begin
				cal_next = cal;
			end
		endcase
	end

	// Change flags
	always_comb begin
		flags.time_touched = cmd inside {cts_pkg::CMD_SECOND, cts_pkg::CMD_MINUTE,
			cts_pkg::CMD_HOUR, cts_pkg::CMD_SEASON, cts_pkg::CMD_LOAD};
		flags.date_touched = hour_wrap || (cmd inside {cts_pkg::CMD_DAY, cts_pkg::CMD_WEEK,
			cts_pkg::CMD_MONTH, cts_pkg::CMD_SEASON, cts_pkg::CMD_YEAR, cts_pkg::CMD_LOAD});
	end

endmodule

[sv/calendar_time_stepper.sv]
// Top level of the calendar time stepper: input register, calendar state and result register.
//
//  channel | dir | payload (tdata, lowest bit first)
//  --------+-----+------------------------------------------------------------------
//  s_*     | in  | command[3:0] load_year[19:4] load_day[28:20] load_hour[33:29]
//          |     | load_minute[39:34] load_second[45:40], zero fill to 48 bits
//  m_*     | out | cur_year[15:0] cur_day[24:16] cur_hour[29:25] cur_minute[35:30]
//          |     | cur_second[41:36] time_touched[42] date_touched[43], zero fill
//
// Each transfer passes from s_ to m_ through the input register, then through the calendar
// step logic into the result register. One transfer per cycle is sustained while m_tready
// stays high; the calendar register is updated as the item moves into the result register.
// Reset sets the calendar to year 1, day 1, 00:00:00 and empties both registers.
// A stall on m_tready holds the result; the input register still takes a transfer while
// the result register is full, then s_tready drops until the result is taken.
`timescale 1ns / 1ps

module calendar_time_stepper (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// command, load_year, load_day, load_hour, load_minute, load_second, zero fill
	input  logic [cts_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// cur_year, cur_day, cur_hour, cur_minute, cur_second, time_touched, date_touched, fill
	output logic [cts_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int OUT_USED_W = $bits(cts_pkg::cal_t) + 2;

	logic            valid_s1;
	cts_pkg::item_t  item_s1;
	cts_pkg::cal_t   cal_q;
	cts_pkg::cal_t   cal_next;
	cts_pkg::flags_t flags;
	cts_pkg::cal_t   res_cal_q;
	cts_pkg::flags_t res_flags_q;
	logic            res_valid_q;
	logic            advance;

	// Stage 1 moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.command     <= s_tdata[3:0];
			item_s1.load.year   <= s_tdata[19:4];
			item_s1.load.day    <= s_tdata[28:20];
			item_s1.load.hour   <= s_tdata[33:29];
			item_s1.load.minute <= s_tdata[39:34];
			item_s1.load.second <= s_tdata[45:40];
		end
	end

	// Calendar step
	cts_step u_step (
		.cal      (cal_q),
		.item     (item_s1),
		.cal_next (cal_next),
		.flags    (flags)
	);

	// Calendar state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.year   <= cts_pkg::YEAR_W'(1);
			cal_q.day    <= cts_pkg::SEASON1_DAY;
			cal_q.hour   <= '0;
			cal_q.minute <= '0;
			cal_q.second <= '0;
		end else if (advance) begin
			cal_q <= cal_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_cal_q   <= cal_next;
			res_flags_q <= flags;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {
		(cts_pkg::OUT_DATA_W - OUT_USED_W)'(0),
		res_flags_q.date_touched,
		res_flags_q.time_touched,
		res_cal_q.second,
		res_cal_q.minute,
		res_cal_q.hour,
		res_cal_q.day,
		res_cal_q.year
	};

endmodule
